// ===== rtl/plwq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plwq_pkg: shared types and codes of the priority lock waiter queue
// Transfer payloads, action and status codes, and the controller states.
// ----------------------------------------------------------------------------
package plwq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF     = 16;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_ACQUIRE = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_QUEUE_FULL   = 2'd1;
  localparam logic [1:0] STAT_QUEUE_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_RELEASE_FREE = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] requester_id;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [1:0]  status;
    logic [15:0] head_id;
    logic [6:0]  waiter_count;
    logic        lock_busy;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PLACE_HEAD,
    S_HEAD_LD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/priority_lock_waiter_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_lock_waiter_queue_top: lock with a sorted waiter queue
// Release, no-op and refused requests go straight to the done state; a grant
// first loads the new head, unless it takes the last waiter. An enqueue writes
// an empty queue at once, else reads and compares entries from the tail down and
// writes the head if the id lands there. One item at a time, next taken once
// the result is queued. Reset clears lock, count, head pointer, not id memory.
// ----------------------------------------------------------------------------
module priority_lock_waiter_queue_top #(
  parameter int QUEUE_DEPTH = plwq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = plwq_pkg::ID_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire plwq_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output plwq_pkg::rsp_t      rsp
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W:0] DEPTH_P = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W:0]   off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= DEPTH_P) begin
      sum = sum - DEPTH_P;
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [ID_BITS-1:0] waiter_ids [QUEUE_DEPTH];

  plwq_pkg::state_t state, state_next;

  logic [CNT_W-1:0]   count, count_next;
  logic [PTR_W-1:0]   head_ptr, head_ptr_next;
  logic [ID_BITS-1:0] head_reg, head_reg_next;
  logic [ID_BITS-1:0] id_r, id_r_next;
  logic [PTR_W-1:0]   k, k_next;
  logic               lock, lock_next;
  logic               grant_r, grant_r_next;
  logic [1:0]         status_r, status_r_next;
  logic               rsp_valid_next;
  plwq_pkg::rsp_t     rsp_next;

  logic [PTR_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] rd_data;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;

  logic               accept;
  logic [ID_BITS-1:0] req_id;
  logic               shift_up;

  assign req_stall = (state != plwq_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign req_id    = ID_BITS'(req.requester_id);
  assign rd_addr   = (state == plwq_pkg::S_SCAN_RD) ? phys(head_ptr, {1'b0, k})
                                                    : phys(head_ptr, (PTR_W + 1)'(1));
  assign shift_up  = (k == '0) ? (rd_data < id_r) : (rd_data <= id_r);

  always_ff @(posedge clk) begin
    rd_data <= waiter_ids[rd_addr];
    if (wr_en) begin
      waiter_ids[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plwq_pkg::S_IDLE;
      count     <= '0;
      head_ptr  <= '0;
      lock      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head_ptr  <= head_ptr_next;
      lock      <= lock_next;
      rsp_valid <= rsp_valid_next;
    end
    head_reg <= head_reg_next;
    id_r     <= id_r_next;
    k        <= k_next;
    grant_r  <= grant_r_next;
    status_r <= status_r_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    head_ptr_next  = head_ptr;
    head_reg_next  = head_reg;
    id_r_next      = id_r;
    k_next         = k;
    lock_next      = lock;
    grant_r_next   = grant_r;
    status_r_next  = status_r;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    wr_en          = 1'b0;
    wr_addr        = head_ptr;
    wr_data        = id_r;

    unique case (state)
      plwq_pkg::S_IDLE: begin
        if (accept) begin
          id_r_next     = req_id;
          grant_r_next  = 1'b0;
          status_r_next = plwq_pkg::STAT_OK;
          state_next    = plwq_pkg::S_DONE;
          unique case (req.action)
            plwq_pkg::ACT_ENQUEUE: begin
              if (count == DEPTH_C) begin
                status_r_next = plwq_pkg::STAT_QUEUE_FULL;
              end else if (count == '0) begin
                wr_en         = 1'b1;
                wr_addr       = head_ptr;
                wr_data       = req_id;
                head_reg_next = req_id;
                count_next    = count + 1'b1;
              end else begin
                k_next     = PTR_W'(count - 1'b1);
                state_next = plwq_pkg::S_SCAN_RD;
              end
            end
            plwq_pkg::ACT_ACQUIRE: begin
              if (count == '0) begin
                status_r_next = plwq_pkg::STAT_QUEUE_EMPTY;
              end else if (head_reg == req_id && !lock) begin
                lock_next     = 1'b1;
                grant_r_next  = 1'b1;
                count_next    = count - 1'b1;
                head_ptr_next = phys(head_ptr, (PTR_W + 1)'(1));
                if (count != CNT_W'(1)) begin
                  state_next = plwq_pkg::S_HEAD_LD;
                end
              end
            end
            plwq_pkg::ACT_RELEASE: begin
              if (!lock) begin
                status_r_next = plwq_pkg::STAT_RELEASE_FREE;
              end else begin
                lock_next = 1'b0;
              end
            end
            plwq_pkg::ACT_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      plwq_pkg::S_SCAN_RD: begin
        state_next = plwq_pkg::S_SCAN_CMP;
      end
      plwq_pkg::S_SCAN_CMP: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_ptr, {1'b0, k} + 1'b1);
        if (shift_up) begin
          wr_data = rd_data;
          if (k == '0) begin
            state_next = plwq_pkg::S_PLACE_HEAD;
          end else begin
            k_next     = k - 1'b1;
            state_next = plwq_pkg::S_SCAN_RD;
          end
        end else begin
          wr_data    = id_r;
          count_next = count + 1'b1;
          state_next = plwq_pkg::S_DONE;
        end
      end
      plwq_pkg::S_PLACE_HEAD: begin
        wr_en         = 1'b1;
        wr_addr       = head_ptr;
        wr_data       = id_r;
        head_reg_next = id_r;
        count_next    = count + 1'b1;
        state_next    = plwq_pkg::S_DONE;
      end
      plwq_pkg::S_HEAD_LD: begin
        head_reg_next = rd_data;
        state_next    = plwq_pkg::S_DONE;
      end
      plwq_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next.granted      = grant_r;
          rsp_next.status       = status_r;
          rsp_next.head_id      = (count != '0) ? 16'(head_reg) : 16'd0;
          rsp_next.waiter_count = 7'(count);
          rsp_next.lock_busy    = lock;
          rsp_valid_next        = 1'b1;
          state_next            = plwq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = plwq_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("waiter count above queue depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != plwq_pkg::S_IDLE)
    else $error("accepted transfer did not start work");

  a_grant_holds_lock: assert property (@(posedge clk) disable iff (rst)
    (state == plwq_pkg::S_DONE) && grant_r |-> lock)
    else $error("grant reported without lock held");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == plwq_pkg::S_IDLE) || (state == plwq_pkg::S_SCAN_CMP) ||
              (state == plwq_pkg::S_PLACE_HEAD))
    else $error("memory write outside insert path");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == plwq_pkg::S_SCAN_CMP) |-> (CNT_W'(k) < count) && (count < DEPTH_C))
    else $error("scan index outside queue");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the priority lock waiter queue
// Sends enqueue, acquire, release and no-op requests over the valid/stall
// request channel. A sorted waiter model in the bench predicts each response,
// and every response transfer is compared field by field, in order. The sender
// mostly works in bursts with gaps. The receiver stalls at random and once holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH         = plwq_pkg::QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 10;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  plwq_pkg::req_t req       = '0;
  logic           rsp_stall = 1'b0;
  logic           req_stall;
  logic           rsp_valid;
  plwq_pkg::rsp_t rsp;

  priority_lock_waiter_queue_top DUT (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0]    waiter_q[$];
  logic           lock_held = 1'b0;
  plwq_pkg::rsp_t expected_rsp[$];
  plwq_pkg::rsp_t oldest_rsp;

  int tx_mode    = 0;
  int burst_left = 0;
  int rx_mode    = 0;
  int hold_req   = 0;
  int hold_left  = 0;

  int items_sent         = 0;
  int rsp_seen           = 0;
  int mismatch_count     = 0;
  int grant_count        = 0;
  int full_count         = 0;
  int empty_count        = 0;
  int free_release_count = 0;
  int peak_waiters       = 0;
  int input_stall_cycles = 0;

  function automatic plwq_pkg::rsp_t lock_queue_predict(input plwq_pkg::req_t r);
    plwq_pkg::rsp_t res;
    int             pos;
    res = '0;
    case (r.action)
      plwq_pkg::ACT_ENQUEUE: begin
        if (waiter_q.size() >= DEPTH) begin
          res.status = plwq_pkg::STAT_QUEUE_FULL;
        end else begin
          if (waiter_q.size() == 0 || waiter_q[0] < r.requester_id) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < waiter_q.size() && waiter_q[pos] > r.requester_id) pos++;
          end
          waiter_q.insert(pos, r.requester_id);
        end
      end
      plwq_pkg::ACT_ACQUIRE: begin
        if (waiter_q.size() == 0) begin
          res.status = plwq_pkg::STAT_QUEUE_EMPTY;
        end else if (waiter_q[0] == r.requester_id && !lock_held) begin
          lock_held = 1'b1;
          void'(waiter_q.pop_front());
          res.granted = 1'b1;
        end
      end
      plwq_pkg::ACT_RELEASE: begin
        if (!lock_held) res.status = plwq_pkg::STAT_RELEASE_FREE;
        else lock_held = 1'b0;
      end
      default: ;
    endcase
    res.head_id      = (waiter_q.size() != 0) ? waiter_q[0] : 16'h0000;
    res.waiter_count = 7'(waiter_q.size());
    res.lock_busy    = lock_held;
    return res;
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 8))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 7));
      3: return (waiter_q.size() != 0) ? waiter_q[0] : 16'($urandom_range(0, 15));
      4: return (waiter_q.size() != 0) ? waiter_q[$urandom_range(0, waiter_q.size() - 1)]
                                       : 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] head_or_random();
    return (waiter_q.size() != 0) ? waiter_q[0] : pick_id();
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [15:0] id);
    plwq_pkg::req_t item;
    plwq_pkg::rsp_t res;
    int             gap;
    item.action       = act;
    item.requester_id = id;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    res = lock_queue_predict(item);
    expected_rsp.push_back(res);
    items_sent++;
    if (res.granted) grant_count++;
    case (res.status)
      plwq_pkg::STAT_QUEUE_FULL:   full_count++;
      plwq_pkg::STAT_QUEUE_EMPTY:  empty_count++;
      plwq_pkg::STAT_RELEASE_FREE: free_release_count++;
      default: ;
    endcase
    if (waiter_q.size() > peak_waiters) peak_waiters = waiter_q.size();
    if (tx_mode != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = (tx_mode == 1) ? $urandom_range(1, 4) : $urandom_range(1, 20);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_results_settled();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_stall) input_stall_cycles++;
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (expected_rsp.size() == 0) begin
          mismatch_count++;
          $display("%0t: response expected none, got %p", $time, rsp);
        end else begin
          oldest_rsp = expected_rsp.pop_front();
          compare_field("granted", oldest_rsp.granted, rsp.granted);
          compare_field("status", oldest_rsp.status, rsp.status);
          compare_field("head_id", oldest_rsp.head_id, rsp.head_id);
          compare_field("waiter_count", oldest_rsp.waiter_count, rsp.waiter_count);
          compare_field("lock_busy", oldest_rsp.lock_busy, rsp.lock_busy);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != 0) begin
      hold_left <= hold_req - 1;
      hold_req  <= 0;
      rsp_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  task automatic test_directed_cases();
    tx_mode = 2;
    rx_mode <= 1;
    send_item(plwq_pkg::ACT_RELEASE, 16'h0000);
    send_item(plwq_pkg::ACT_ACQUIRE, 16'hFFFF);
    send_item(plwq_pkg::ACT_NOP, 16'hFFFF);
    send_item(plwq_pkg::ACT_ENQUEUE, 16'h0000);
    send_item(plwq_pkg::ACT_ENQUEUE, 16'h8000);
    send_item(plwq_pkg::ACT_ENQUEUE, 16'h8000);
    send_item(plwq_pkg::ACT_ENQUEUE, 16'hFFFF);
    send_item(plwq_pkg::ACT_ENQUEUE, 16'h0000);
    send_item(plwq_pkg::ACT_ENQUEUE, 16'h7FFF);
    send_item(plwq_pkg::ACT_ACQUIRE, 16'h8000);
    send_item(plwq_pkg::ACT_ACQUIRE, 16'hFFFF);
    send_item(plwq_pkg::ACT_ACQUIRE, 16'h8000);
    send_item(plwq_pkg::ACT_RELEASE, 16'h1234);
    send_item(plwq_pkg::ACT_ACQUIRE, 16'h8000);
    send_item(plwq_pkg::ACT_RELEASE, 16'hFFFF);
    send_item(plwq_pkg::ACT_ACQUIRE, 16'h8000);
    send_item(plwq_pkg::ACT_NOP, 16'h0000);
    send_item(plwq_pkg::ACT_RELEASE, 16'h5555);
    send_item(plwq_pkg::ACT_RELEASE, 16'hAAAA);
    wait_results_settled();
  endtask

  task automatic test_queue_full();
    int k;
    tx_mode = 1;
    rx_mode <= 1;
    while (waiter_q.size() < DEPTH) send_item(plwq_pkg::ACT_ENQUEUE, pick_id());
    for (k = 0; k < 4; k++) send_item(plwq_pkg::ACT_ENQUEUE, pick_id());
    send_item(plwq_pkg::ACT_ACQUIRE, ~waiter_q[0]);
    send_item(plwq_pkg::ACT_NOP, 16'($urandom));
    while (waiter_q.size() != 0) begin
      send_item(plwq_pkg::ACT_ACQUIRE, waiter_q[0]);
      if (waiter_q.size() == 0) send_item(plwq_pkg::ACT_ACQUIRE, 16'hFFFF);
      send_item(plwq_pkg::ACT_RELEASE, 16'($urandom));
    end
    wait_results_settled();
  endtask

  task automatic test_output_backpressure();
    int k;
    tx_mode = 0;
    hold_req <= 400;
    for (k = 0; k < 60; k++) begin
      case (k % 4)
        0:       send_item(plwq_pkg::ACT_ENQUEUE, pick_id());
        1:       send_item(plwq_pkg::ACT_ACQUIRE, head_or_random());
        2:       send_item(plwq_pkg::ACT_RELEASE, 16'($urandom));
        default: send_item(plwq_pkg::ACT_NOP, 16'($urandom));
      endcase
    end
    wait_results_settled();
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int k;
    int m;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) begin
        tx_mode = $urandom_range(0, 2);
        rx_mode <= $urandom_range(0, 2);
      end
      if ($urandom_range(0, 99) == 0) wait_results_settled();
      if ($urandom_range(0, 99) < 75) begin
        k = (waiter_q.size() > 32) ? 0 : $urandom_range(1, 3);
        m = $urandom_range(1, 3);
        repeat (k) send_item(plwq_pkg::ACT_ENQUEUE, pick_id());
        repeat (m) begin
          if ($urandom_range(0, 3) == 0) send_item(plwq_pkg::ACT_ACQUIRE, pick_id());
          send_item(plwq_pkg::ACT_ACQUIRE, head_or_random());
          if ($urandom_range(0, 3) == 0) send_item(plwq_pkg::ACT_ACQUIRE, head_or_random());
          send_item(plwq_pkg::ACT_RELEASE, 16'($urandom));
        end
      end else begin
        send_item(2'($urandom_range(0, 3)), pick_id());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_queue_full();
    test_output_backpressure();
    test_random_traffic(850);
    rx_mode <= 0;
    wait_results_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d request and %0d response transfers: %0d grants, %0d full drops,",
             items_sent, rsp_seen, grant_count, full_count);
    $display("%0d empty attempts, %0d free releases, peak depth %0d, %0d input stall cycles.",
             empty_count, free_release_count, peak_waiters, input_stall_cycles);
    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_count, expected_rsp.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d responses outstanding", expected_rsp.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
